@@ rtl/core/hvd_pkg.sv @@
package hvd_pkg;

  // default number of cordic micro-rotations
  localparam int CORDIC_STAGES = 24;

  // q2.30 angle or trig value
  typedef logic signed [31:0] q30_t;

  localparam logic signed [30:0] LAT_LIMIT     = 31'sd900000000;
  localparam logic signed [33:0] LON_HALF_TURN = 34'sd1800000000;
  localparam logic signed [33:0] LON_TURN      = 34'sd3600000000;

  // pi*2^31 / 3.6e9 and pi*2^31 / 7.2e9, both reduced by the common factor 4
  localparam logic [30:0] RAD_MUL   = 31'd1686629713;
  localparam logic [30:0] DIV_FULL  = 31'd900000000;
  localparam logic [30:0] DIV_HALF  = 31'd1800000000;
  // floor(2^61 / divisor), quotient estimate from the top 32 dividend bits
  localparam logic [31:0] RECIP_FULL = 32'd2562047788;
  localparam logic [31:0] RECIP_HALF = 32'd1281023894;

  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic [60:0]        ONE_Q60     = 61'h1000_0000_0000_0000;
  localparam int                 SQRT_STEPS  = 31;
  localparam logic [29:0]        RADIUS_CM   = 30'd637100000;
  localparam logic [30:0]        HALF_CIRC   = 31'd2001508680;

  // atan(2^-i) in q30, rounded
  function automatic logic [30:0] atan_q30(int i);
    logic [63:0] t;
    t = ((64'd1 << 31) >> i) + 64'd1;
    case (i)
      0: return 31'd843314857;
      1: return 31'd497837829;
      2: return 31'd263043837;
      3: return 31'd133525159;
      4: return 31'd67021687;
      5: return 31'd33543516;
      6: return 31'd16775851;
      7: return 31'd8388437;
      8: return 31'd4194283;
      9: return 31'd2097149;
      default: return 31'(t >> 1);
    endcase
  endfunction

endpackage

@@ rtl/core/hvd_rad.sv @@
module hvd_rad (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic signed [30:0] lat_a,
  input  logic signed [31:0] lon_a,
  input  logic signed [30:0] lat_b,
  input  logic signed [31:0] lon_b,
  output logic               out_vld,
  output hvd_pkg::q30_t      ang [4]
);

  // lanes: half dlat, half dlon, lat a, lat b
  localparam int LAT = 8;

  logic [LAT-1:0]      vld_r;
  hvd_pkg::q30_t       v_r [4];
  logic [61:0]         prod_r [4];
  logic                sg_r [6][4];
  logic [61:0]         n_r [4][4];
  logic [63:0]         pq_r [4];
  logic [30:0]         qe_r [3][4];
  logic [61:0]         qd_r [4];
  logic [32:0]         r_r [4];
  logic [30:0]         q_nxt [4];
  hvd_pkg::q30_t       ang_r [4];

  logic signed [30:0]  la_c, lb_c;
  logic signed [31:0]  la_w, lb_w;
  logic signed [33:0]  oa_w, ob_w, dlon_nxt;

  function automatic logic [30:0] dvsr(int l);
    return (l < 2) ? hvd_pkg::DIV_HALF : hvd_pkg::DIV_FULL;
  endfunction

  function automatic logic [31:0] recip(int l);
    return (l < 2) ? hvd_pkg::RECIP_HALF : hvd_pkg::RECIP_FULL;
  endfunction

  function automatic logic [61:0] dhalf(int l);
    return 62'(dvsr(l) >> 1);
  endfunction

  always_comb begin
    la_c = lat_a;
    if (lat_a > hvd_pkg::LAT_LIMIT) la_c = hvd_pkg::LAT_LIMIT;
    else if (lat_a < -hvd_pkg::LAT_LIMIT) la_c = -hvd_pkg::LAT_LIMIT;
    lb_c = lat_b;
    if (lat_b > hvd_pkg::LAT_LIMIT) lb_c = hvd_pkg::LAT_LIMIT;
    else if (lat_b < -hvd_pkg::LAT_LIMIT) lb_c = -hvd_pkg::LAT_LIMIT;
    la_w = 32'(la_c);
    lb_w = 32'(lb_c);
    oa_w = 34'(lon_a);
    ob_w = 34'(lon_b);
    dlon_nxt = ob_w - oa_w;
    if (dlon_nxt >= hvd_pkg::LON_HALF_TURN) dlon_nxt = dlon_nxt - hvd_pkg::LON_TURN;
    else if (dlon_nxt < -hvd_pkg::LON_HALF_TURN) dlon_nxt = dlon_nxt + hvd_pkg::LON_TURN;
  end

  // the estimate is low by at most two, fixed up from the remainder
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      q_nxt[l] = qe_r[2][l] + 31'(r_r[l] >= 33'(dvsr(l)))
               + 31'(r_r[l] >= 33'({dvsr(l), 1'b0}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r[0] <= lb_w - la_w;
      v_r[1] <= dlon_nxt[31:0];
      v_r[2] <= la_w;
      v_r[3] <= lb_w;
      for (int l = 0; l < 4; l++) begin
        // magnitude times the scaled pi ratio
        sg_r[0][l] <= v_r[l][31];
        prod_r[l]  <= 62'(v_r[l][31] ? 31'(-v_r[l]) : v_r[l][30:0]) * 62'(hvd_pkg::RAD_MUL);
        for (int k = 0; k < 5; k++) begin
          sg_r[k+1][l] <= sg_r[k][l];
        end
        n_r[0][l] <= prod_r[l] + dhalf(l);
        for (int k = 0; k < 3; k++) begin
          n_r[k+1][l] <= n_r[k][l];
        end
        // reciprocal multiply on the top dividend bits
        pq_r[l]    <= 64'(n_r[0][l][61:30]) * 64'(recip(l));
        qe_r[0][l] <= pq_r[l][61:31];
        qe_r[1][l] <= qe_r[0][l];
        qe_r[2][l] <= qe_r[1][l];
        qd_r[l]    <= 62'(qe_r[0][l]) * 62'(dvsr(l));
        r_r[l]     <= 33'(n_r[3][l] - qd_r[l]);
        ang_r[l] <= sg_r[5][l] ? -$signed({1'b0, q_nxt[l]}) : $signed({1'b0, q_nxt[l]});
      end
    end
  end

  assign out_vld = vld_r[LAT-1];
  assign ang     = ang_r;

endmodule

@@ rtl/core/hvd_rot.sv @@
module hvd_rot #(
  parameter int STAGES = hvd_pkg::CORDIC_STAGES
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  hvd_pkg::q30_t ang [4],
  output logic          out_vld,
  output hvd_pkg::q30_t s_lat,
  output hvd_pkg::q30_t s_lng,
  output hvd_pkg::q30_t c_a,
  output hvd_pkg::q30_t c_b
);

  logic [STAGES:0]    vld_r;
  logic signed [32:0] x_r [STAGES+1][4];
  logic signed [32:0] y_r [STAGES+1][4];
  logic signed [32:0] z_r [STAGES+1][4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STAGES-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        x_r[0][l] <= hvd_pkg::CORDIC_GAIN;
        y_r[0][l] <= '0;
        z_r[0][l] <= 33'(ang[l]);
        for (int k = 0; k < STAGES; k++) begin
          if (z_r[k][l] >= 0) begin
            x_r[k+1][l] <= x_r[k][l] - (y_r[k][l] >>> k);
            y_r[k+1][l] <= y_r[k][l] + (x_r[k][l] >>> k);
            z_r[k+1][l] <= z_r[k][l] - $signed({2'b00, hvd_pkg::atan_q30(k)});
          end else begin
            x_r[k+1][l] <= x_r[k][l] + (y_r[k][l] >>> k);
            y_r[k+1][l] <= y_r[k][l] - (x_r[k][l] >>> k);
            z_r[k+1][l] <= z_r[k][l] + $signed({2'b00, hvd_pkg::atan_q30(k)});
          end
        end
      end
    end
  end

  assign out_vld = vld_r[STAGES];
  assign s_lat   = y_r[STAGES][0][31:0];
  assign s_lng   = y_r[STAGES][1][31:0];
  assign c_a     = x_r[STAGES][2][31:0];
  assign c_b     = x_r[STAGES][3][31:0];

endmodule

@@ rtl/core/hvd_hav.sv @@
module hvd_hav (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  hvd_pkg::q30_t s_lat,
  input  hvd_pkg::q30_t s_lng,
  input  hvd_pkg::q30_t c_a,
  input  hvd_pkg::q30_t c_b,
  output logic          out_vld,
  output logic [60:0]   hav_a,
  output logic [60:0]   hav_b
);

  localparam logic signed [63:0] RND = 64'sd536870912;

  logic [6:0]         vld_r;
  logic signed [63:0] pcc_r, pu_r, pa_r;
  logic signed [63:0] sq_r [5];
  hvd_pkg::q30_t      sl_r [4];
  hvd_pkg::q30_t      cc_r, u_r;
  logic [60:0]        a_r, a2_r, b_r;
  logic signed [64:0] sum_nxt;

  assign sum_nxt = 65'(sq_r[4]) + 65'(pa_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pcc_r   <= 64'(c_a) * 64'(c_b);
      sq_r[0] <= 64'(s_lat) * 64'(s_lat);
      sl_r[0] <= s_lng;
      cc_r    <= 32'((pcc_r + RND) >>> 30);
      sq_r[1] <= sq_r[0];
      sl_r[1] <= sl_r[0];
      pu_r    <= 64'(cc_r) * 64'(sl_r[1]);
      sq_r[2] <= sq_r[1];
      sl_r[2] <= sl_r[1];
      u_r     <= 32'((pu_r + RND) >>> 30);
      sq_r[3] <= sq_r[2];
      sl_r[3] <= sl_r[2];
      pa_r    <= 64'(u_r) * 64'(sl_r[3]);
      sq_r[4] <= sq_r[3];
      // clamp to [0, 1] in q60
      if (sum_nxt < 0) a_r <= '0;
      else if (sum_nxt > $signed(65'(hvd_pkg::ONE_Q60))) a_r <= hvd_pkg::ONE_Q60;
      else a_r <= sum_nxt[60:0];
      a2_r <= a_r;
      b_r  <= hvd_pkg::ONE_Q60 - a_r;
    end
  end

  assign out_vld = vld_r[6];
  assign hav_a   = a2_r;
  assign hav_b   = b_r;

endmodule

@@ rtl/core/hvd_sqrt.sv @@
module hvd_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [60:0] val,
  output logic        out_vld,
  output logic [30:0] root
);

  localparam int NS = hvd_pkg::SQRT_STEPS;

  logic [NS:0]  vld_r;
  logic [61:0]  v_r [NS+1];
  logic [61:0]  res_r [NS+1];

  function automatic logic [61:0] bitk(int k);
    return 62'd1 << (2 * (NS - 1 - k));
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r[0]   <= 62'(val);
      res_r[0] <= '0;
      for (int k = 0; k < NS; k++) begin
        if (v_r[k] >= res_r[k] + bitk(k)) begin
          v_r[k+1]   <= v_r[k] - (res_r[k] + bitk(k));
          res_r[k+1] <= (res_r[k] >> 1) + bitk(k);
        end else begin
          v_r[k+1]   <= v_r[k];
          res_r[k+1] <= res_r[k] >> 1;
        end
      end
    end
  end

  assign out_vld = vld_r[NS];
  assign root    = res_r[NS][30:0];

endmodule

@@ rtl/core/hvd_vec.sv @@
module hvd_vec #(
  parameter int STAGES = hvd_pkg::CORDIC_STAGES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [30:0] ry,
  input  logic [30:0] rx,
  output logic        out_vld,
  output logic [30:0] dist_cm
);

  localparam int LAT = STAGES + 4;

  logic [LAT-1:0]     vld_r;
  logic signed [32:0] x_r [STAGES+1];
  logic signed [32:0] y_r [STAGES+1];
  logic signed [32:0] z_r [STAGES+1];
  logic [32:0]        c_r;
  logic [62:0]        p_r;
  logic [30:0]        d_r;
  logic [33:0]        d_nxt;

  assign d_nxt = 34'((p_r + 63'd536870912) >> 30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= $signed({2'b00, rx});
      y_r[0] <= $signed({2'b00, ry});
      z_r[0] <= '0;
      for (int k = 0; k < STAGES; k++) begin
        if (y_r[k] >= 0) begin
          x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] + $signed({2'b00, hvd_pkg::atan_q30(k)});
        end else begin
          x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] - $signed({2'b00, hvd_pkg::atan_q30(k)});
        end
      end
      // central angle is twice the half angle, never negative
      c_r <= z_r[STAGES][32] ? '0 : {z_r[STAGES][31:0], 1'b0};
      p_r <= 63'(c_r) * 63'(hvd_pkg::RADIUS_CM);
      d_r <= (d_nxt > 34'(hvd_pkg::HALF_CIRC)) ? hvd_pkg::HALF_CIRC : d_nxt[30:0];
    end
  end

  assign out_vld = vld_r[LAT-1];
  assign dist_cm = d_r;

endmodule

@@ rtl/core/haversine_distance.sv @@
// great-circle distance between two points, haversine on a 6371 km sphere,
// answered in rounded centimetres and saturated at half the circumference.
// one point pair is taken per clock while the pipeline is not stalled; the
// pipeline is made of the 8 stages of the degree-to-radian scaling (reciprocal
// multiply with a small remainder fix-up), the cordic rotation stages plus one,
// the 7-stage product chain, the 32 square-root stages, the cordic vectoring
// stages plus 4 for the radius scaling, and the output register. latitudes
// beyond +-90 degrees are clamped and the longitude difference wraps, so every
// input bit pattern gives a result. the pipeline stalls as a whole only when
// the output register and the skid register both hold results not yet taken;
// in_tready comes from a register and has no path from out_tready.
module haversine_distance #(
  parameter int CORDIC_STAGES = hvd_pkg::CORDIC_STAGES
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // lat_a [30:0], lon_a [62:31], lat_b [93:63], lon_b [125:94], zero pad
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // distance_cm [30:0], zero pad
  output logic [31:0]  out_tdata
);

  // pipeline advance, held while the skid register is full
  logic en;

  logic          rad_vld, rot_vld, hav_vld, sq_a_vld, sq_b_vld, pipe_vld;
  hvd_pkg::q30_t ang [4];
  hvd_pkg::q30_t s_lat, s_lng, c_a, c_b;
  logic [60:0]   hav_a, hav_b;
  logic [30:0]   ry, rx, pipe_d;

  logic          out_v_r, skid_v_r;
  logic [30:0]   out_d_r, skid_d_r;
  logic          take;

  assign en        = ~skid_v_r;
  assign in_tready = en;
  assign take      = out_v_r & out_tready;

  // degree to q2.30 radians, with latitude clamp and longitude wrap
  hvd_rad u_rad (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_tvalid),
    .lat_a   ($signed(in_tdata[30:0])),
    .lon_a   ($signed(in_tdata[62:31])),
    .lat_b   ($signed(in_tdata[93:63])),
    .lon_b   ($signed(in_tdata[125:94])),
    .out_vld (rad_vld),
    .ang     (ang)
  );

  // sines of the half differences, cosines of the latitudes
  hvd_rot #(.STAGES(CORDIC_STAGES)) u_rot (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (rad_vld),
    .ang     (ang),
    .out_vld (rot_vld),
    .s_lat   (s_lat),
    .s_lng   (s_lng),
    .c_a     (c_a),
    .c_b     (c_b)
  );

  // haversine term a and its complement in q60
  hvd_hav u_hav (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (rot_vld),
    .s_lat   (s_lat),
    .s_lng   (s_lng),
    .c_a     (c_a),
    .c_b     (c_b),
    .out_vld (hav_vld),
    .hav_a   (hav_a),
    .hav_b   (hav_b)
  );

  hvd_sqrt u_sqrt_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (hav_vld),
    .val     (hav_a),
    .out_vld (sq_a_vld),
    .root    (ry)
  );

  hvd_sqrt u_sqrt_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (hav_vld),
    .val     (hav_b),
    .out_vld (sq_b_vld),
    .root    (rx)
  );

  // atan2 and scaling by the radius
  hvd_vec #(.STAGES(CORDIC_STAGES)) u_vec (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (sq_a_vld & sq_b_vld),
    .ry      (ry),
    .rx      (rx),
    .out_vld (pipe_vld),
    .dist_cm (pipe_d)
  );

  // output register with a skid register behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (!out_v_r || take) begin
        if (skid_v_r) begin
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end else begin
          out_v_r <= en & pipe_vld;
        end
      end else if (en && pipe_vld) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || take) begin
      if (skid_v_r) out_d_r <= skid_d_r;
      else if (en && pipe_vld) out_d_r <= pipe_d;
    end else if (en && pipe_vld) begin
      skid_d_r <= pipe_d;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_d_r};

`ifndef SYNTHESIS
  // a result waits in the skid register only behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a result while output is empty");

  // a held skid result stays put until the output moves
  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !take) |=> (skid_v_r && $stable(skid_d_r)))
    else $error("skid result changed while stalled");

  // the skid result moves forward on the transaction that frees the output
  a_skid_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && take) |=> (out_v_r && out_d_r == $past(skid_d_r) && !skid_v_r))
    else $error("skid result not forwarded");

  // distance never exceeds half the circumference
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_d_r <= hvd_pkg::HALF_CIRC))
    else $error("distance beyond half circumference");
`endif

endmodule

@@ tb/hvd_checker.sv @@
module hvd_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [127:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [31:0]  out_tdata,
  output int           errors,
  output int           pending
);

  localparam longint unsigned PI_Q31  = 64'd6746518852;
  localparam longint          GAIN    = 64'sd652032874;
  localparam longint          ONE60   = 64'sd1 << 60;
  localparam longint          LAT_MAX = 64'sd900000000;
  localparam longint          HALF    = 64'sd1800000000;
  localparam longint          TURN    = 64'sd3600000000;
  localparam longint          RAD_CM  = 64'sd637100000;
  localparam longint          SAT_CM  = 64'sd2001508680;

  logic [30:0] dist_q[$];

  function automatic longint arctan_step(int i);
    case (i)
      0: return 843314857;
      1: return 497837829;
      2: return 263043837;
      3: return 133525159;
      4: return 67021687;
      5: return 33543516;
      6: return 16775851;
      7: return 8388437;
      8: return 4194283;
      9: return 2097149;
      default: return longint'((((64'd1 << 31) >> i) + 64'd1) >> 1);
    endcase
  endfunction

  function automatic longint rad_from_deg(longint v, longint unsigned div);
    longint unsigned m;
    longint r;
    m = (v < 0) ? longint'(-v) : v;
    r = longint'((m * PI_Q31 + div / 2) / div);
    return (v < 0) ? -r : r;
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    return (a * b + (64'sd1 << 29)) >>> 30;
  endfunction

  function automatic void rotate(input longint ang, output longint sn, output longint cs);
    longint x, y, z, dx, dy;
    x = GAIN;
    y = 0;
    z = ang;
    for (int i = 0; i < hvd_pkg::CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_step(i);
      end else begin
        x += dx; y -= dy; z += arctan_step(i);
      end
    end
    sn = y;
    cs = x;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < hvd_pkg::CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arctan_step(i);
      end else begin
        x -= dx; y += dy; z -= arctan_step(i);
      end
    end
    return z;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint clip_lat(longint v);
    if (v > LAT_MAX) return LAT_MAX;
    if (v < -LAT_MAX) return -LAT_MAX;
    return v;
  endfunction

  function automatic logic [30:0] great_circle_cm(logic [127:0] d);
    longint la, oa, lb, ob, dlat, dlon, s_lat, s_lng, c_a, c_b, junk, u, a60, c, dist_cm;
    la = clip_lat(longint'($signed(d[30:0])));
    oa = longint'($signed(d[62:31]));
    lb = clip_lat(longint'($signed(d[93:63])));
    ob = longint'($signed(d[125:94]));
    dlat = lb - la;
    dlon = ob - oa;
    if (dlon >= HALF) dlon -= TURN;
    else if (dlon < -HALF) dlon += TURN;
    rotate(rad_from_deg(dlat, 64'd7200000000), s_lat, junk);
    rotate(rad_from_deg(dlon, 64'd7200000000), s_lng, junk);
    rotate(rad_from_deg(la, 64'd3600000000), junk, c_a);
    rotate(rad_from_deg(lb, 64'd3600000000), junk, c_b);
    u = mul_q30(mul_q30(c_a, c_b), s_lng);
    a60 = s_lat * s_lat + u * s_lng;
    if (a60 < 0) a60 = 0;
    if (a60 > ONE60) a60 = ONE60;
    c = 2 * vector_angle(longint'(floor_sqrt(a60)), longint'(floor_sqrt(ONE60 - a60)));
    if (c < 0) c = 0;
    dist_cm = longint'((unsigned'(c) * unsigned'(RAD_CM) + (64'd1 << 29)) >> 30);
    if (dist_cm > SAT_CM) dist_cm = SAT_CM;
    return dist_cm[30:0];
  endfunction

  assign pending = dist_q.size();

  always @(posedge clk) begin
    logic [30:0] want;
    if (!rst_n) begin
      errors <= 0;
    end else begin
      if (in_tvalid && in_tready) dist_q.push_back(great_circle_cm(in_tdata));
      if (out_tvalid && out_tready) begin
        if (dist_q.size() == 0) begin
          if (errors < 10) $display("unexpected result %0d", out_tdata[30:0]);
          errors <= errors + 1;
        end else begin
          want = dist_q.pop_front();
          if (out_tdata[30:0] !== want || out_tdata[31] !== 1'b0) begin
            if (errors < 10)
              $display("distance_cm mismatch: expected %0d got %0d (raw %h)",
                       want, out_tdata[30:0], out_tdata);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

@@ tb/tb.sv @@
module tb;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [31:0]  out_tdata;
  int           errors;
  int           pending;

  // idle odds in percent for each side, and a forced receiver hold-off
  int           tx_idle_pct = 0;
  int           rx_stall_pct = 0;
  logic         rx_hold = 1'b0;

  always #4 clk = ~clk;

  haversine_distance DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  hvd_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .errors(errors), .pending(pending)
  );

  // receiver side: random stalls, or held off completely
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // lat [30:0], lon [31:0] for each point, packed lowest bits first
  function automatic logic [127:0] pack_pair(logic [30:0] lat_a, logic [31:0] lon_a,
                                             logic [30:0] lat_b, logic [31:0] lon_b);
    return {2'b00, lon_b, lat_b, lon_a, lat_a};
  endfunction

  function automatic int rand_lat();
    return int'($urandom_range(1800000000)) - 900000000;
  endfunction

  function automatic int rand_lon();
    return int'($urandom_range(3600000000)) - 1800000000;
  endfunction

  // mostly valid coordinates, plus close pairs, near-antipodal pairs and raw bits
  function automatic logic [127:0] random_pair();
    int la, oa, lb, ob;
    la = rand_lat();
    oa = rand_lon();
    case ($urandom_range(4))
      0: begin
        lb = la + int'($urandom_range(20000)) - 10000;
        ob = oa + int'($urandom_range(20000)) - 10000;
      end
      1: begin
        lb = -la + int'($urandom_range(2000)) - 1000;
        ob = oa + 1800000000 + int'($urandom_range(2000)) - 1000;
      end
      2: return {2'b00, 126'({$urandom, $urandom, $urandom, $urandom})};
      default: begin
        lb = rand_lat();
        ob = rand_lon();
      end
    endcase
    return pack_pair(la[30:0], oa, lb[30:0], ob);
  endfunction

  // one transaction on the input side, with random idle cycles ahead of it
  task automatic send(logic [127:0] pair);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pair;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic run_phase(int tx_pct, int rx_pct, int count);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (count) send(random_pair());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: same point, poles, equator, wrap, antipodes, clamped latitudes
    send(pack_pair(31'sd0, 32'sd0, 31'sd0, 32'sd0));
    send(pack_pair(31'sd900000000, 32'sd0, -31'sd900000000, 32'sd0));
    send(pack_pair(31'sd0, 32'sd0, 31'sd0, 32'sd1800000000));
    send(pack_pair(31'sd0, -32'sd1800000000, 31'sd0, 32'sd1800000000));
    send(pack_pair(31'sd0, 32'sd1799999999, 31'sd0, -32'sd1799999999));
    send(pack_pair(31'sd0, 32'sd0, 31'sd0, -32'sd1800000000));
    send(pack_pair(31'sd0, 32'sd0, 31'sd0, 32'sd1799999999));
    send(pack_pair(31'sd450000000, 32'sd100000000, -31'sd450000000, -32'sd1700000000));
    send(pack_pair(31'h3fffffff, 32'h7fffffff, 31'h40000000, 32'h80000000));
    send(pack_pair(31'h40000000, 32'h80000000, 31'h3fffffff, 32'h7fffffff));
    send(pack_pair(31'h7fffffff, 32'hffffffff, 31'h7fffffff, 32'h00000001));
    send(pack_pair(31'sd900000001, 32'h80000000, 31'sd0, 32'h7fffffff));
    send(pack_pair(31'sd123456789, 32'sd987654321, 31'sd123456790, 32'sd987654321));
    send(pack_pair(31'sd515000000, -32'sd1200000, 31'sd488000000, 32'sd23500000));
    send(pack_pair(31'sd899999999, 32'sd0, 31'sd899999999, 32'sd1800000000));
    send(pack_pair(-31'sd899999999, 32'sd0, -31'sd899999999, 32'sd1));
    send(pack_pair(31'sd1, 32'sd0, -31'sd1, 32'sd1800000000));

    run_phase(0, 0, 40);

    // long receiver hold-off while input keeps coming, until the block backs up
    fork
      begin
        rx_hold = 1'b1;
        repeat (400) @(posedge clk);
        rx_hold = 1'b0;
      end
      run_phase(0, 0, 150);
    join

    run_phase(82, 0, 70);
    run_phase(0, 82, 70);
    run_phase(38, 38, 70);
    run_phase(0, 0, 40);
    in_tvalid <= 1'b0;
    tx_idle_pct = 0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/hvd_pkg.sv
rtl/core/hvd_rad.sv
rtl/core/hvd_rot.sv
rtl/core/hvd_hav.sv
rtl/core/hvd_sqrt.sv
rtl/core/hvd_vec.sv
rtl/core/haversine_distance.sv
tb/hvd_checker.sv
tb/tb.sv
